// ===== hdl/slcb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcb_pkg
// Shared constants, lane control/status types and the draw test for the
// slime chunk batch checker.
// ----------------------------------------------------------------------------
package slcb_pkg;

   // Widths fixed by the transaction fields
   localparam int unsigned COORD_W = 32;
   localparam int unsigned SEED_W  = 64;
   localparam int unsigned LCG_W   = 48;
   localparam int unsigned HALF_W  = 24;
   localparam int unsigned DRAW_W  = 31;
   localparam int unsigned OUT_W   = 8;
   localparam int unsigned ADDR_W  = 4;

   // Chunk seed coefficients
   localparam logic [31:0] XQ_K   = 32'd4987142;
   localparam logic [31:0] XLIN_K = 32'd5947611;
   localparam logic [23:0] ZQ_K   = 24'd4392871;
   localparam logic [31:0] ZLIN_K = 32'd389711;
   localparam logic [47:0] CS_XOR = 48'd987234911;

   // 48-bit LCG
   localparam logic [34:0] LCG_MUL = 35'h5DEECE66D;
   localparam logic [47:0] LCG_ADD = 48'hB;

   // Draws at or above this value are rejected by the bias check
   localparam logic [30:0] REJ_LIMIT = 31'h7FFF_FFF8;

   // Register address bit that selects the seed register
   localparam logic REG_WORLD_SEED = 1'b0;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL1 = 6'b000010,
      ST_MUL2 = 6'b000100,
      ST_SUM  = 6'b001000,
      ST_INIT = 6'b010000,
      ST_RUN  = 6'b100000
   } state_type;

   // Step strobes from the sequencer to every lane
   typedef struct packed {
      logic mul1;
      logic mul2;
      logic sum;
      logic init;
   } lane_ctl_type;

   // Lane result back to the merge stage
   typedef struct packed {
      logic done;
      logic flag;
   } lane_sts_type;

   // True when a 31-bit draw is a multiple of ten: even, and a multiple of
   // five (16 = 1 mod 5, so the nibble sum keeps the residue).
   function automatic logic draw_is_tenth(input logic [30:0] bits);
      logic [6:0] nsum;
      logic [4:0] fold;
      logic [4:0] r;
      nsum = 7'({4'b0, bits[3:0]}) + 7'({4'b0, bits[7:4]})
           + 7'({4'b0, bits[11:8]}) + 7'({4'b0, bits[15:12]})
           + 7'({4'b0, bits[19:16]}) + 7'({4'b0, bits[23:20]})
           + 7'({4'b0, bits[27:24]}) + 7'({5'b0, bits[30:28]});
      fold = 5'({2'b0, nsum[6:4]}) + 5'({1'b0, nsum[3:0]});
      r = fold;
      if (r >= 5'd20) begin
         r = r - 5'd20;
      end
      if (r >= 5'd10) begin
         r = r - 5'd10;
      end
      if (r >= 5'd5) begin
         r = r - 5'd5;
      end
      return (bits[0] == 1'b0) && (r == 5'd0);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/slime_chunk_batch_check_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slime_chunk_batch_check_top
// Tests a row of LANES consecutive chunks against the world seed and
// returns one slime flag per lane; lanes past the output width are not reported.
//
//   channel  direction  handshake                      payload
//   req      in         req_valid / req_stall          req_x_start, req_z_row
//   rsp      out        rsp_valid / rsp_stall          rsp_slime_flags
//   csr      in         APB psel/penable/pwrite/pready world_seed (64 bits)
//
// One transaction at a time: the sequencer steps through MUL1, MUL2, SUM and
// INIT to the start of the LCG loop; each lane splits every LCG step into
// products, then add, and redraws on rejection, so the slowest lane sets when
// the row is merged, after which the sequencer returns to idle.
// Synchronous active-high reset clears the sequencer and the output valid;
// world_seed resets to 0. A finished result waits in the output register
// under rsp_stall while the next transaction is accepted and computed.
// ----------------------------------------------------------------------------
module slime_chunk_batch_check_top
   import slcb_pkg::*;
#(
   parameter int unsigned LANES = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // input transactions
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [COORD_W-1:0]  req_x_start,
   input  wire logic [COORD_W-1:0]  req_z_row,
   // result transactions
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [OUT_W-1:0]    rsp_slime_flags,
   // configuration
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [ADDR_W-1:0]   csr_paddr,
   input  wire logic [SEED_W-1:0]   csr_pwdata,
   output      logic [SEED_W-1:0]   csr_prdata,
   output      logic                csr_pready
);

   state_type          state_ff, state_in;
   logic [SEED_W-1:0]  seed_ff;
   logic [COORD_W-1:0] x_ff, z_ff;
   logic [31:0]        zz_ff, zz_in;
   logic [31:0]        zlin_ff, zlin_in;
   logic [LCG_W-1:0]   zq_ff, zq_in;
   logic [LCG_W-1:0]   row_ff, row_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   flags_ff, flags_in;

   logic signed [55:0] zq_full;
   logic               req_take, csr_write, all_done, out_free, finish;
   lane_ctl_type       ctl;
   logic [LANES-1:0]   done_vec, flag_vec;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_WORLD_SEED) ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_write && (csr_paddr[3] == REG_WORLD_SEED)) begin
         seed_ff <= csr_pwdata;
      end
   end

   // row terms shared by all lanes
   assign zz_in   = z_ff * z_ff;
   assign zlin_in = z_ff * ZLIN_K;
   assign zq_full = $signed(zz_ff) * $signed({1'b0, ZQ_K});
   assign zq_in   = zq_full[LCG_W-1:0];
   assign row_in  = seed_ff[LCG_W-1:0] + zq_ff + {{(LCG_W-32){zlin_ff[31]}}, zlin_ff};

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= req_x_start;
         z_ff <= req_z_row;
      end
      if (ctl.mul1) begin
         zz_ff   <= zz_in;
         zlin_ff <= zlin_in;
      end
      if (ctl.mul2) begin
         zq_ff <= zq_in;
      end
      if (ctl.sum) begin
         row_ff <= row_in;
      end
   end

   // sequencer
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign all_done  = &done_vec;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_RUN) && all_done && out_free;

   assign ctl.mul1 = (state_ff == ST_MUL1);
   assign ctl.mul2 = (state_ff == ST_MUL2);
   assign ctl.sum  = (state_ff == ST_SUM);
   assign ctl.init = (state_ff == ST_INIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_INIT;
         ST_INIT: state_in = ST_RUN;
         ST_RUN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // lanes
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      lane_sts_type sts;
      slcb_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .x_chunk (x_ff + COORD_W'(k)),
         .row_sum (row_ff),
         .sts     (sts)
      );
      assign done_vec[k] = sts.done;
      assign flag_vec[k] = sts.flag;
   end

   // merge: lanes past the output width are not reported
   for (genvar b = 0; b < OUT_W; b++) begin : g_merge
      if (b < LANES) begin : g_used
         assign flags_in[b] = flag_vec[b];
      end else begin : g_unused
         assign flags_in[b] = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slime_flags = flags_ff;

endmodule
`default_nettype wire

// ===== hdl/slcb_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcb_lane
// One chunk: builds the x part of the chunk seed, scrambles it into the LCG
// state and steps the LCG (products, then add) until a draw passes the bias
// check. Reports done and whether the draw is a multiple of ten.
// ----------------------------------------------------------------------------
module slcb_lane
   import slcb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lane_ctl_type       ctl,
   input  wire logic [COORD_W-1:0] x_chunk,
   input  wire logic [LCG_W-1:0]   row_sum,
   output lane_sts_type            sts
);

   logic [31:0]       xx_ff,   xx_in;
   logic [31:0]       xlin_ff, xlin_in;
   logic [31:0]       xq_ff,   xq_in;
   logic [LCG_W-1:0]  xsum_ff, xsum_in;
   logic [LCG_W-1:0]  s_ff,    s_in;
   logic [LCG_W-1:0]  plo_ff,  plo_in;
   logic [HALF_W-1:0] phi_ff,  phi_in;
   logic              run_ff,   run_in;
   logic              add_ff,   add_in;
   logic              fresh_ff, fresh_in;
   logic              done_ff,  done_in;
   logic              flag_ff,  flag_in;

   logic [58:0]       plo_full;
   logic [47:0]       phi_full;
   logic [DRAW_W-1:0] bits;
   logic              reject;

   // seed terms that depend on x
   assign xx_in   = x_chunk * x_chunk;
   assign xlin_in = x_chunk * XLIN_K;
   assign xq_in   = xx_ff * XQ_K;
   assign xsum_in = {{(LCG_W-32){xq_ff[31]}}, xq_ff}
                  + {{(LCG_W-32){xlin_ff[31]}}, xlin_ff};

   // LCG partial products, low half full width, high half mod 2^24
   assign plo_full = {35'b0, s_ff[HALF_W-1:0]} * {24'b0, LCG_MUL};
   assign phi_full = {24'b0, s_ff[LCG_W-1:HALF_W]} * {24'b0, LCG_MUL[HALF_W-1:0]};
   assign plo_in   = plo_full[LCG_W-1:0];
   assign phi_in   = phi_full[HALF_W-1:0];

   // draw check on the current state
   assign bits   = s_ff[LCG_W-1:17];
   assign reject = (bits >= REJ_LIMIT);

   // step control
   always_comb begin
      s_in     = s_ff;
      run_in   = run_ff;
      add_in   = add_ff;
      fresh_in = fresh_ff;
      done_in  = done_ff;
      flag_in  = flag_ff;
      if (ctl.init) begin
         s_in     = (row_sum + xsum_ff) ^ CS_XOR ^ {13'b0, LCG_MUL};
         run_in   = 1'b1;
         add_in   = 1'b0;
         fresh_in = 1'b0;
         done_in  = 1'b0;
      end else if (run_ff && add_ff) begin
         s_in     = plo_ff + {phi_ff, {HALF_W{1'b0}}} + LCG_ADD;
         add_in   = 1'b0;
         fresh_in = 1'b1;
      end else if (run_ff) begin
         if (fresh_ff && !reject) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            flag_in = draw_is_tenth(bits);
         end else begin
            add_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul1) begin
         xx_ff   <= xx_in;
         xlin_ff <= xlin_in;
      end
      if (ctl.mul2) begin
         xq_ff <= xq_in;
      end
      if (ctl.sum) begin
         xsum_ff <= xsum_in;
      end
      if (run_ff && !add_ff) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      s_ff    <= s_in;
      flag_ff <= flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         add_ff   <= 1'b0;
         fresh_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         add_ff   <= add_in;
         fresh_ff <= fresh_in;
         done_ff  <= done_in;
      end
   end

   assign sts.done = done_ff;
   assign sts.flag = flag_ff;

endmodule
`default_nettype wire

// ===== bench/tb_slime_chunk_batch_check_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slime_chunk_batch_check_top
// Drives rows of chunk coordinates into the slime chunk batch checker under
// several world seeds and compares every returned flag byte against a
// bit-accurate behavioral predictor of the chunk seed and Java LCG draw.
// ----------------------------------------------------------------------------
module tb_slime_chunk_batch_check_top;
   import slcb_pkg::*;

   localparam int unsigned NUM_LANES = 8;
   localparam int          SEED_REG  = 0;
   localparam int          SPARE_REG = 1;
   localparam logic [ADDR_W-1:0] SEED_ADDR  = 4'h0;
   localparam logic [ADDR_W-1:0] SPARE_ADDR = 4'h8;
   localparam int          ITEMS_PER_PHASE = 190;
   localparam int          NUM_PHASES      = 6;
   localparam int          DRAIN_CYCLES    = 12;
   localparam int          MAX_REPORTS     = 50;

   // Expected flag bytes in arrival order, plus a private copy of the seed
   class slime_row_scoreboard;
      logic [SEED_W-1:0] seed_value;
      logic [OUT_W-1:0]  pending_flags[$];
      int                errors;

      function new();
         seed_value = '0;
         errors = 0;
      endfunction

      function void set_register(int index, logic [SEED_W-1:0] value);
         if (index == SEED_REG) begin
            seed_value = value;
         end
      endfunction

      // Chunk seed, LCG scramble and nextInt(10) with rejection, per lane
      function logic [OUT_W-1:0] slime_flags_for_row(logic [COORD_W-1:0] x0,
                                                     logic [COORD_W-1:0] z);
         logic [OUT_W-1:0]   flags;
         logic [COORD_W-1:0] x, xx, zz, t;
         logic [SEED_W-1:0]  cs;
         logic [LCG_W-1:0]   s;
         logic [31:0]        draw, rem;
         bit                 accepted;
         flags = '0;
         zz = z * z;
         for (int k = 0; k < NUM_LANES; k++) begin
            x  = x0 + 32'(k);
            xx = x * x;
            t  = xx * 32'd4987142;
            cs = seed_value + {{32{t[31]}}, t};
            t  = x * 32'd5947611;
            cs = cs + {{32{t[31]}}, t};
            cs = cs + {{32{zz[31]}}, zz} * 64'd4392871;
            t  = z * 32'd389711;
            cs = cs + {{32{t[31]}}, t};
            cs = cs ^ 64'd987234911;
            s  = cs[47:0] ^ 48'h5DEECE66D;
            accepted = 1'b0;
            while (!accepted) begin
               s    = s * 48'h5DEECE66D + 48'hB;
               draw = {1'b0, s[47:17]};
               rem  = draw % 32'd10;
               // bias check: redraw when the bucket runs past 2^31
               if (draw - rem + 32'd9 < 32'h8000_0000) begin
                  accepted = 1'b1;
                  if (rem == 32'd0 && k < OUT_W) begin
                     flags[k] = 1'b1;
                  end
               end
            end
         end
         return flags;
      endfunction

      function void note_row(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] z);
         pending_flags.push_back(slime_flags_for_row(x0, z));
      endfunction

      function void check_flags(logic [OUT_W-1:0] actual);
         logic [OUT_W-1:0] expected;
         if (pending_flags.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: unexpected result transaction, actual %h", $time, actual);
            end
            return;
         end
         expected = pending_flags.pop_front();
         if (actual !== expected) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: slime_flags mismatch, expected %h actual %h",
                        $time, expected, actual);
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [COORD_W-1:0]  req_x_start = '0;
   logic [COORD_W-1:0]  req_z_row = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [OUT_W-1:0]    rsp_slime_flags;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [SEED_W-1:0]   csr_pwdata = '0;
   logic [SEED_W-1:0]   csr_prdata;
   logic                csr_pready;

   bit                  no_idle = 1'b0;
   slime_row_scoreboard sb;

   slime_chunk_batch_check_top #(
      .LANES(NUM_LANES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_x_start(req_x_start),
      .req_z_row(req_z_row),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_slime_flags(rsp_slime_flags),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // Receiver: random stall, none during the steady stretch
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 19);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_flags(rsp_slime_flags);
      end
   end

   // Watchdog
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   // One row transaction; valid stays high afterwards unless the caller rests
   task automatic send_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] z);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_x_start <= x;
      req_z_row   <= z;
      do @(posedge clock); while (req_stall);
      sb.note_row(x, z);
   endtask

   // Stop sending and wait until the block has returned everything
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_flags.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [SEED_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(int'(addr) / 8, data);
      @(posedge clock);
   endtask

   task automatic csr_check_seed();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== sb.seed_value) begin
         sb.errors++;
         $display("%0t: world_seed readback mismatch, expected %h actual %h",
                  $time, sb.seed_value, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mix of full-range, near-zero and near-extreme coordinates
   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 2000)) - 32'd1000;
         1: return 32'h7FFF_FFF0 + 32'($urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [SEED_W-1:0] seed;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under the reset seed: zero, wraps and extremes
      csr_check_seed();
      send_row(32'h0000_0000, 32'h0000_0000);
      send_row(32'h0000_0001, 32'h0000_0000);
      send_row(32'h0000_0000, 32'h0000_0001);
      send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_row(32'h7FFF_FFFC, 32'h0000_0000);    // lanes wrap to negative x
      send_row(32'hFFFF_FFF8, 32'h0000_0000);    // lanes stay just below zero
      send_row(32'hFFFF_FFFC, 32'h0000_0005);
      send_row(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_row(32'h8000_0000, 32'h8000_0000);
      send_row(32'h8000_0000, 32'h7FFF_FFFF);
      send_row(32'h7FFF_FFFF, 32'h8000_0000);
      send_row(32'h0000_0000, 32'h8000_0000);
      send_row(32'h0000_0000, 32'h7FFF_FFFF);
      send_row(32'hFFFF_FFFF, 32'h0000_0000);
      send_row(32'h1234_5678, 32'hEDCB_A988);
      send_row(32'hAAAA_AAAA, 32'h5555_5555);
      send_row(32'h5555_5555, 32'hAAAA_AAAA);
      send_row(32'd100, -32'sd200);
      send_row(-32'sd64, 32'd64);
      send_row(32'd46341, 32'd46341);             // squares overflow signed 32 bits
      drain();

      // Seed phases: extremes first, then random seeds
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: seed = 64'h7FFF_FFFF_FFFF_FFFF;
            1: seed = 64'h8000_0000_0000_0000;
            2: seed = 64'hFFFF_FFFF_FFFF_FFFF;
            default: seed = {$urandom, $urandom};
         endcase
         csr_write(SEED_ADDR, seed);
         if (p == 2) begin
            // write to an unmapped register must leave the seed alone
            csr_write(SPARE_ADDR, {$urandom, $urandom});
         end
         csr_check_seed();
         no_idle = (p == 0);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 1 && i == ITEMS_PER_PHASE / 2) begin
               drain();
            end
            send_row(random_coord(), random_coord());
         end
         drain();
         no_idle = 1'b0;
      end

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
